[sv/bcss_pkg.sv]
// package: shared types and constants for the box center-surround saliency block
package bcss_pkg;

  localparam int CfgMapWidth  = 0;
  localparam int CfgMapHeight = 1;
  localparam int CfgBoxLeft   = 2;
  localparam int CfgBoxTop    = 3;
  localparam int CfgBoxWidth  = 4;
  localparam int CfgBoxHeight = 5;

  localparam int SumBits  = 40;
  localparam int AreaBits = 25;
  localparam int ProdBits = 66;

  typedef struct packed {
    logic [SumBits-1:0]  inner_sum;
    logic [SumBits-1:0]  outer_sum;
    logic [AreaBits-1:0] inner_area;
    logic [AreaBits-1:0] outer_area;
  } frame_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

[sv/bcss_front.sv]
// front end: raster position, box tests and the two running sums
module bcss_front #(
  parameter int MAX_DIM    = 4096,
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            pixel,
  input  logic                  frame_start,
  input  logic [12:0]           map_width,
  input  logic [12:0]           map_height,
  input  logic [11:0]           box_left,
  input  logic [11:0]           box_top,
  input  logic [12:0]           box_width,
  input  logic [12:0]           box_height,
  output logic                  job_valid,
  input  logic                  job_ready,
  output bcss_pkg::frame_job_t  job
);

  localparam int MD = MAX_DIM;

  logic [11:0] column_count, row_count;
  logic [bcss_pkg::SumBits-1:0] inner_sum, outer_sum;
  logic [13:0] w, h;
  logic [13:0] cil, cih, col, coh, ril, rih, rol, roh;
  logic [11:0] cc, rc;
  logic [bcss_pkg::SumBits-1:0] is0, os0, is1, os1;
  logic [15:0] pix;
  logic last_col, last_px, acc;

  function automatic logic [13:0] eff(input logic [12:0] v);
    if (v == 13'd0) return 14'd1;
    if ({1'b0, v} > 14'(MD)) return 14'(MD);
    return {1'b0, v};
  endfunction

  // spans along one axis: inner [ilo,ihi) and clipped surround [olo,ohi)
  function automatic logic [55:0] spans(input logic [11:0] s, input logic [12:0] l,
                                        input logic [13:0] lim);
    logic [13:0] e, ihi, olo, hi;
    logic [19:0] a, b, c;
    logic [20:0] s21;
    logic [41:0] pa, pc;
    e = {2'b0, s} + {1'b0, l};
    ihi = (e < lim) ? e : lim;
    if (ihi < {2'b0, s}) ihi = {2'b0, s};
    a = 20'(s) * 20'd100;
    b = 20'(l) * 20'd21;
    // divide by 100 as a multiply by ceil(2^27/100), exact for operands below 1.8e6
    pa = 42'(a - b) * 42'd1342178;
    olo = (a > b) ? 14'(pa >> 27) : 14'd0;
    s21 = 21'(a) + 21'(l) * 21'd121;
    pc = 42'(s21) * 42'd1342178;
    c = 20'(pc >> 27);
    hi = (c > 20'(lim)) ? lim : c[13:0];
    if (hi < olo) hi = olo;
    return {{2'b0, s}, ihi, olo, hi};
  endfunction

  always_comb begin
    w = eff(map_width);
    h = eff(map_height);
    {cil, cih, col, coh} = spans(box_left, box_width, w);
    {ril, rih, rol, roh} = spans(box_top, box_height, h);
    pix = 16'(pixel) & 16'((32'd1 << PIXEL_BITS) - 1);
    is0 = frame_start ? '0 : inner_sum;
    os0 = frame_start ? '0 : outer_sum;
    cc = frame_start ? 12'd0 : column_count;
    rc = frame_start ? 12'd0 : row_count;
    if ({2'b0, cc} >= w) cc = 12'd0;
    if ({2'b0, rc} >= h) rc = 12'd0;
    is1 = is0;
    os1 = os0;
    if ({2'b0, cc} >= cil && {2'b0, cc} < cih && {2'b0, rc} >= ril && {2'b0, rc} < rih)
      is1 = is0 + bcss_pkg::SumBits'(pix);
    if ({2'b0, cc} >= col && {2'b0, cc} < coh && {2'b0, rc} >= rol && {2'b0, rc} < roh)
      os1 = os0 + bcss_pkg::SumBits'(pix);
    last_col = ({2'b0, cc} + 14'd1) >= w;
    last_px  = last_col && (({2'b0, rc} + 14'd1) >= h);
  end

  // pixels stall while a finished frame still waits in the job slot
  assign in_ready = !job_valid || job_ready;
  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      inner_sum <= '0;
      outer_sum <= '0;
      job_valid <= 1'b0;
    end else begin
      job_valid <= (acc && last_px) || (job_valid && !job_ready);
      if (acc) begin
        if (last_px) begin
          column_count <= '0;
          row_count <= '0;
          inner_sum <= '0;
          outer_sum <= '0;
          job.inner_sum <= is1;
          job.outer_sum <= os1;
          job.inner_area <= bcss_pkg::AreaBits'(26'(cih - cil) * 26'(rih - ril));
          job.outer_area <= bcss_pkg::AreaBits'(26'(coh - col) * 26'(roh - rol));
        end else begin
          inner_sum <= is1;
          outer_sum <= os1;
          column_count <= last_col ? 12'd0 : cc + 12'd1;
          row_count <= last_col ? rc + 12'd1 : rc;
        end
      end
    end
  end

endmodule

[sv/bcss_back.sv]
// back end: cross products and a restoring divider, one quotient bit a cycle
module bcss_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  bcss_pkg::frame_job_t job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [8:0]           score,
  output logic                 no_ring
);

  localparam int PB = bcss_pkg::ProdBits;
  localparam int QB = 7;

  bcss_pkg::back_state_t state, state_next;
  logic [bcss_pkg::SumBits-1:0] isum, rsum;
  logic [bcss_pkg::AreaBits-1:0] iarea, rarea;
  logic [PB-1:0] num, den, rem;
  logic [2:0] phase;
  logic [QB-1:0] bitcnt;
  logic [PB-1:0] quo;
  logic neg;
  logic [PB:0] trial;

  always_comb begin
    state_next = state;
    unique case (state)
      bcss_pkg::BK_IDLE: if (job_valid) state_next = bcss_pkg::BK_MUL;
      bcss_pkg::BK_MUL:  if (phase == 3'd2) state_next = bcss_pkg::BK_DIV;
      bcss_pkg::BK_DIV:  if (bitcnt == QB'(0)) state_next = bcss_pkg::BK_DONE;
      bcss_pkg::BK_DONE: if (out_ready) state_next = bcss_pkg::BK_IDLE;
      default: state_next = bcss_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state == bcss_pkg::BK_IDLE);
    out_valid = (state == bcss_pkg::BK_DONE);
    trial = {1'b0, rem[PB-2:0], num[PB-1]} - {1'b0, den};
    if (no_ring) score = 9'd0;
    else score = neg ? 9'(-quo) : quo[8:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcss_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      bcss_pkg::BK_IDLE: begin
        isum <= job.inner_sum;
        rsum <= (job.outer_sum > job.inner_sum) ? job.outer_sum - job.inner_sum : '0;
        iarea <= job.inner_area;
        rarea <= (job.outer_area > job.inner_area) ? job.outer_area - job.inner_area : '0;
        phase <= 3'd0;
      end
      bcss_pkg::BK_MUL: begin
        phase <= phase + 3'd1;
        if (phase == 3'd0) begin
          num <= PB'(isum) * PB'(rarea);
          den <= PB'(iarea) * PB'(rarea);
        end else if (phase == 3'd1) begin
          rem <= PB'(rsum) * PB'(iarea);
        end else begin
          neg <= num < rem;
          num <= (num < rem) ? rem - num : num - rem;
          rem <= '0;
          quo <= '0;
          bitcnt <= QB'(PB - 1);
          no_ring <= (den == '0);
        end
      end
      bcss_pkg::BK_DIV: begin
        bitcnt <= bitcnt - QB'(1);
        num <= num << 1;
        if (!trial[PB]) begin
          rem <= trial[PB-1:0];
          quo <= {quo[PB-2:0], 1'b1};
        end else begin
          rem <= {rem[PB-2:0], num[PB-1]};
          quo <= {quo[PB-2:0], 1'b0};
        end
      end
      bcss_pkg::BK_DONE: ;
      default: ;
    endcase
  end

endmodule

[sv/box_center_surround_saliency.sv]
// top level: config registers, front end, one-job queue, divider back end
//  channel | dir | fields
//  s_axis  | in  | tdata[7:0]=pixel, tuser=frame_start
//  m_axis  | out | tdata[8:0]=score, tuser=no_ring
//  apb     | in  | six registers at 4*i
// one pixel a cycle in the front end when not stalled; the score follows the last
// pixel of a frame through one hand-off, three multiply steps and 66 divider steps
// pixels stall while a finished frame waits in the job slot, i.e. when a frame
// ends before the back end has delivered the score of the one before
// rst is synchronous; registers return to 640x480 map, 1x1 box at 0,0
module box_center_surround_saliency #(
  parameter int MAX_DIM    = 4096,
  parameter int PIXEL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // score[8:0], zero fill
  output logic        m_axis_tuser,   // no_ring
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0] map_width, map_height, box_width, box_height;
  logic [11:0] box_left, box_top;
  logic job_valid, job_ready;
  bcss_pkg::frame_job_t job;
  logic [8:0] score;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width <= 13'd640;
      map_height <= 13'd480;
      box_left <= '0;
      box_top <= '0;
      box_width <= 13'd1;
      box_height <= 13'd1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[1:0] == 2'b00) begin
        unique case (32'(ridx))
          bcss_pkg::CfgMapWidth:  map_width <= pwdata[12:0];
          bcss_pkg::CfgMapHeight: map_height <= pwdata[12:0];
          bcss_pkg::CfgBoxLeft:   box_left <= pwdata[11:0];
          bcss_pkg::CfgBoxTop:    box_top <= pwdata[11:0];
          bcss_pkg::CfgBoxWidth:  box_width <= pwdata[12:0];
          bcss_pkg::CfgBoxHeight: box_height <= pwdata[12:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (32'(ridx))
      bcss_pkg::CfgMapWidth:  prdata = 32'(map_width);
      bcss_pkg::CfgMapHeight: prdata = 32'(map_height);
      bcss_pkg::CfgBoxLeft:   prdata = 32'(box_left);
      bcss_pkg::CfgBoxTop:    prdata = 32'(box_top);
      bcss_pkg::CfgBoxWidth:  prdata = 32'(box_width);
      bcss_pkg::CfgBoxHeight: prdata = 32'(box_height);
      default:                prdata = 32'd0;
    endcase
  end

  bcss_front #(.MAX_DIM(MAX_DIM), .PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .pixel(s_axis_tdata), .frame_start(s_axis_tuser),
    .map_width, .map_height, .box_left, .box_top, .box_width, .box_height,
    .job_valid, .job_ready, .job
  );

  bcss_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .score, .no_ring(m_axis_tuser)
  );

  assign m_axis_tdata = {7'd0, score};

endmodule

[sv/bcss_checker.sv]
// checker: port-level properties of the saliency block
module bcss_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        pready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

  a_noring: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("score not zero with no ring");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)
    else $error("tdata padding not zero");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("back-to-back results");

  a_ready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind box_center_surround_saliency bcss_checker u_chk (.*);
